[rtl/ncv_pkg.sv]
// Shared types, constants and check functions for the nickname charset validator.
package ncv_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_MAP_0  = 3'd0;
    localparam logic [2:0] REG_MAP_1  = 3'd1;
    localparam logic [2:0] REG_MAP_2  = 3'd2;
    localparam logic [2:0] REG_MAP_3  = 3'd3;
    localparam logic [2:0] REG_GROUPS = 3'd4;

    // Reset contents of the allowed-byte map
    localparam logic [63:0] MAP_0_RESET = 64'd287984085547089920;
    localparam logic [63:0] MAP_1_RESET = 64'd4611686018427387902;
    localparam logic [63:0] MAP_2_RESET = 64'd0;
    localparam logic [63:0] MAP_3_RESET = 64'd0;

    // Byte values with a meaning of their own
    localparam logic [7:0] CHAR_DASH     = 8'h2d;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;

    // Group select bits
    localparam logic [2:0] GROUP_KANA       = 3'b001;
    localparam logic [2:0] GROUP_SIMPLIFIED = 3'b010;
    localparam logic [2:0] GROUP_EXTENDED   = 3'b100;

    typedef struct packed {
        logic [7:0] lo1;
        logic [7:0] hi1;
        logic [7:0] lo2;
        logic [7:0] hi2;
        logic [2:0] group;
    } pair_range_t;

    localparam int NUM_RANGES  = 9;
    localparam int NUM_ILLEGAL = 16;

    localparam pair_range_t PAIR_RANGES [NUM_RANGES] = '{
        '{8'ha4, 8'ha4, 8'ha1, 8'hf3, GROUP_KANA},
        '{8'ha5, 8'ha5, 8'ha1, 8'hf6, GROUP_KANA},
        '{8'hb0, 8'hd6, 8'ha1, 8'hfe, GROUP_SIMPLIFIED},
        '{8'hd7, 8'hd7, 8'ha1, 8'hf9, GROUP_SIMPLIFIED},
        '{8'hd8, 8'hf7, 8'ha1, 8'hfe, GROUP_SIMPLIFIED},
        '{8'h81, 8'ha0, 8'h40, 8'h7e, GROUP_EXTENDED},
        '{8'h81, 8'ha0, 8'h80, 8'hfe, GROUP_EXTENDED},
        '{8'haa, 8'hfe, 8'h40, 8'h7e, GROUP_EXTENDED},
        '{8'haa, 8'hfe, 8'h80, 8'ha0, GROUP_EXTENDED}
    };

    // Punctuation refused in double-byte mode, plus the non-breaking space
    localparam logic [7:0] ILLEGAL_SET [NUM_ILLEGAL] = '{
        8'ha0, 8'h21, 8'h2b, 8'h25, 8'h40, 8'h26, 8'h7e, 8'h23,
        8'h24, 8'h3a, 8'h27, 8'h22, 8'h3f, 8'h2a, 8'h2c, 8'h2e
    };

    // Flag control bytes, space and the fixed illegal set
    function automatic logic is_illegal(input logic [7:0] b);
        logic hit;
        hit = (b <= CHAR_SPACE);
        for (int i = 0; i < NUM_ILLEGAL; i++)
        begin
            if (ILLEGAL_SET[i] == b)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Match a lead and trail byte against every enabled range
    function automatic logic pair_ok(input logic [2:0] groups,
                                     input logic [7:0] first,
                                     input logic [7:0] second);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_RANGES; i++)
        begin
            if (((groups & PAIR_RANGES[i].group) != 3'b000) &&
                (first >= PAIR_RANGES[i].lo1) && (first <= PAIR_RANGES[i].hi1) &&
                (second >= PAIR_RANGES[i].lo2) && (second <= PAIR_RANGES[i].hi2))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

[rtl/ncv_in_if.sv]
// Byte request channel into the nickname charset validator.
interface ncv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_byte;
    logic       final_byte;

    modport source (output valid, output name_byte, output final_byte, input ready);
    modport sink   (input valid, input name_byte, input final_byte, output ready);
endinterface

[rtl/ncv_out_if.sv]
// Verdict request channel out of the nickname charset validator.
interface ncv_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [4:0] kept_length;

    modport source (output valid, output accepted, output kept_length, input ready);
    modport sink   (input valid, input accepted, input kept_length, output ready);
endinterface

[rtl/nickname_charset_validator_unit.sv]
// Top level of the nickname charset validator: byte checks, name state and APB registers.
// The block takes one nickname byte per cycle on in_ch and gives one verdict on out_ch for
// each byte marked final_byte: accepted and the kept length (0 when rejected or empty).
// Each byte is captured in an input register, checked in one pass of compare logic against
// the allowed-byte map and the double-byte ranges, and the verdict is held in an output
// register, so a byte can be taken every cycle, also while a verdict waits to be taken;
// a final byte stalls only when the output register is still full. A verdict is
// registered behind the input register. The map and the range groups are written through
// the APB port at byte address 8*index, 64-bit data, and should change only between names.
module nickname_charset_validator_unit #(
    parameter int MAX_NAME_BYTES = 30
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    ncv_in_if.sink      in_ch,
    ncv_out_if.source   out_ch
);

    localparam int CNT_W = $clog2(MAX_NAME_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NAME_BYTES);

    // Configuration registers
    logic [63:0] map_0_reg;
    logic [63:0] map_1_reg;
    logic [63:0] map_2_reg;
    logic [63:0] map_3_reg;
    logic [2:0]  groups_reg;

    // Input register
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_final_reg;

    // Name state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pend_reg;
    logic             pend_next;
    logic [7:0]       lead_reg;
    logic [7:0]       lead_next;
    logic             rej_reg;
    logic             rej_next;

    // Output register
    logic        out_valid_reg;
    logic        accepted_reg;
    logic [4:0]  kept_reg;
    logic        accepted_next;
    logic [4:0]  kept_next;

    logic        wr_en;
    logic [2:0]  reg_index;
    logic        s1_process;
    logic        out_free;
    logic        multi;
    logic        allowed;
    logic [63:0] map_word;
    logic [CNT_W-1:0]   kept_count;
    logic [CNT_W+4:0]   kept_wide;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign wr_en     = psel && penable && pwrite && pready;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_0_reg  <= ncv_pkg::MAP_0_RESET;
            map_1_reg  <= ncv_pkg::MAP_1_RESET;
            map_2_reg  <= ncv_pkg::MAP_2_RESET;
            map_3_reg  <= ncv_pkg::MAP_3_RESET;
            groups_reg <= 3'b000;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                ncv_pkg::REG_MAP_0:  map_0_reg  <= pwdata;
                ncv_pkg::REG_MAP_1:  map_1_reg  <= pwdata;
                ncv_pkg::REG_MAP_2:  map_2_reg  <= pwdata;
                ncv_pkg::REG_MAP_3:  map_3_reg  <= pwdata;
                ncv_pkg::REG_GROUPS: groups_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Return register contents on reads
    always_comb
    begin
        unique case (reg_index)
            ncv_pkg::REG_MAP_0:  prdata = map_0_reg;
            ncv_pkg::REG_MAP_1:  prdata = map_1_reg;
            ncv_pkg::REG_MAP_2:  prdata = map_2_reg;
            ncv_pkg::REG_MAP_3:  prdata = map_3_reg;
            ncv_pkg::REG_GROUPS: prdata = {61'd0, groups_reg};
            default:             prdata = 64'd0;
        endcase
    end

    // Advance the input register unless a final byte waits on a full output
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_process  = s1_valid_reg && (!s1_final_reg || out_free);
    assign in_ch.ready = !s1_valid_reg || s1_process;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_byte_reg  <= in_ch.name_byte;
            s1_final_reg <= in_ch.final_byte;
        end
    end

    // Look up the allowed flag for the byte
    always_comb
    begin
        case (s1_byte_reg[7:6])
            2'd0:    map_word = map_0_reg;
            2'd1:    map_word = map_1_reg;
            2'd2:    map_word = map_2_reg;
            default: map_word = map_3_reg;
        endcase
    end
    assign allowed = map_word[s1_byte_reg[5:0]];
    assign multi   = (groups_reg != 3'b000);

    // Check the byte and update the name state
    always_comb
    begin
        count_next = count_reg;
        pend_next  = pend_reg;
        lead_next  = lead_reg;
        rej_next   = rej_reg;
        if (!rej_reg && (count_reg < CNT_MAX))
        begin
            if ((count_reg == '0) &&
                ((s1_byte_reg == ncv_pkg::CHAR_DASH) ||
                 ((s1_byte_reg >= ncv_pkg::CHAR_ZERO) &&
                  (s1_byte_reg <= ncv_pkg::CHAR_NINE))))
            begin
                rej_next = 1'b1;
            end
            else if (!multi)
            begin
                if (!allowed)
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (ncv_pkg::is_illegal(s1_byte_reg))
            begin
                rej_next = 1'b1;
            end
            else if (pend_reg)
            begin
                if (!ncv_pkg::pair_ok(groups_reg, lead_reg, s1_byte_reg))
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    count_next = count_reg + 1'b1;
                end
            end
            else if (s1_byte_reg[7])
            begin
                pend_next  = 1'b1;
                lead_next  = s1_byte_reg;
                count_next = count_reg + 1'b1;
            end
            else if (!allowed)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Drop a dangling lead byte and form the verdict
    always_comb
    begin
        kept_count = count_next;
        if (pend_next && (count_next != '0))
        begin
            kept_count = count_next - 1'b1;
        end
        kept_wide = {5'd0, kept_count};
        if (rej_next || (kept_count == '0))
        begin
            accepted_next = 1'b0;
            kept_next     = 5'd0;
        end
        else
        begin
            accepted_next = 1'b1;
            kept_next     = kept_wide[4:0];
        end
    end

    // Hold the name state, clearing it after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            lead_reg  <= 8'd0;
            rej_reg   <= 1'b0;
        end
        else if (s1_process)
        begin
            if (s1_final_reg)
            begin
                count_reg <= '0;
                pend_reg  <= 1'b0;
                lead_reg  <= 8'd0;
                rej_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                pend_reg  <= pend_next;
                lead_reg  <= lead_next;
                rej_reg   <= rej_next;
            end
        end
    end

    // Hold the verdict until the sink takes the request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_process && s1_final_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_process && s1_final_reg)
        begin
            accepted_reg <= accepted_next;
            kept_reg     <= kept_next;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.accepted    = accepted_reg;
    assign out_ch.kept_length = kept_reg;

endmodule
